FILE: sv/swamm_pkg.sv
// Shared types and constants of the sliding-window average, minimum and maximum block.
package swamm_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int AXES      = 3;
   localparam int CFG_W     = 11;
   localparam int SUM_W     = SAMPLE_W + CFG_W;
   localparam int DIV_CNT_W = $clog2(SUM_W + 1);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_x;
      logic signed [SAMPLE_W-1:0] sample_y;
      logic signed [SAMPLE_W-1:0] sample_z;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mean_x;
      logic signed [SAMPLE_W-1:0] mean_y;
      logic signed [SAMPLE_W-1:0] mean_z;
      logic signed [SAMPLE_W-1:0] low_x;
      logic signed [SAMPLE_W-1:0] high_x;
      logic signed [SAMPLE_W-1:0] low_y;
      logic signed [SAMPLE_W-1:0] high_y;
      logic signed [SAMPLE_W-1:0] low_z;
      logic signed [SAMPLE_W-1:0] high_z;
   } rsp_type;

endpackage

FILE: sv/sliding_window_avg_min_max_core.sv
// Top level of the sliding-window average, minimum and maximum block.
//
// The block takes one three-axis sample per req_ transaction and returns one
// result per sample on the rsp_ channel: per axis the mean of the most recent
// window_length samples (truncated toward zero) and their minimum and maximum.
// The window length is written through the csr_ channel, which is always ready;
// it should only be written while no transaction is in progress. A length of
// zero acts as one, and a length above WINDOW_DEPTH acts as WINDOW_DEPTH.
// Samples are held in a single ring memory with a registered read port. One
// item is worked on at a time: the accept cycle writes the sample, then the
// older entries are read one per memory cycle, and a restoring divider
// produces one quotient bit per cycle for all three axes together. The next
// item is accepted as soon as the previous one has been handed to the output
// register. The result sits in an output register: a stalled receiver does
// not stop the next transaction from being accepted, but it does hold back
// the one after. Synchronous reset empties the window logically: a fill count
// records how many entries have been written, and unwritten entries read as
// zero, so no clearing pass over the memory is needed.
module sliding_window_avg_min_max_core #(
   parameter int WINDOW_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  swamm_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output swamm_pkg::rsp_type            rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [swamm_pkg::CFG_W-1:0]   csr_data
);

   localparam int SW     = swamm_pkg::SAMPLE_W;
   localparam int NAX    = swamm_pkg::AXES;
   localparam int LW     = swamm_pkg::CFG_W;
   localparam int SUMW   = swamm_pkg::SUM_W;
   localparam int DCW    = swamm_pkg::DIV_CNT_W;
   localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int CMP_W  = (FILL_W > LW) ? FILL_W : LW;
   localparam int ROW_W  = SW * NAX;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff;

   // Configuration and ring bookkeeping.
   logic [LW-1:0]        cfg_len_ff;
   logic [ADDR_W-1:0]    newest_ff;
   logic [FILL_W-1:0]    fill_ff;

   // Ring memory, one row holds all three axes.
   logic [ROW_W-1:0]     sample_ring_ff [WINDOW_DEPTH];
   logic [ROW_W-1:0]     rd_data_ff;
   logic [ADDR_W-1:0]    rd_ptr_ff;

   // Scan control.
   logic [LW-1:0]        len_ff;
   logic [LW-1:0]        iss_k_ff;
   logic                 pend_ff;
   logic                 pend_zero_ff;

   // Per-axis accumulators and divider lanes.
   logic signed [SUMW-1:0] sum_ff [NAX];
   logic signed [SW-1:0]   lo_ff  [NAX];
   logic signed [SW-1:0]   hi_ff  [NAX];
   logic [SUMW-1:0]        quo_ff [NAX];
   logic [LW-1:0]          rem_ff [NAX];
   logic                   neg_ff [NAX];
   logic [DCW-1:0]         div_cnt_ff;

   logic                 rsp_valid_ff;
   swamm_pkg::rsp_type   rsp_data_ff;

   // Combinational helpers.
   logic [ADDR_W-1:0]      new_slot;
   logic [LW-1:0]          eff_len;
   logic                   req_fire;
   logic                   issue;
   logic signed [SW-1:0]   samp   [NAX];
   logic signed [SW-1:0]   rd_val [NAX];
   logic signed [SUMW-1:0] sum_in [NAX];
   logic signed [SW-1:0]   lo_in  [NAX];
   logic signed [SW-1:0]   hi_in  [NAX];
   logic [SUMW-1:0]        mag_in [NAX];
   logic [LW:0]            trial  [NAX];
   logic                   qbit   [NAX];
   logic [LW-1:0]          rem_in [NAX];
   logic signed [SW-1:0]   mean   [NAX];

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign samp[0] = req_data.sample_x;
   assign samp[1] = req_data.sample_y;
   assign samp[2] = req_data.sample_z;

   // The slot that the new sample goes into, one past the newest with wrap.
   assign new_slot = (newest_ff == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : newest_ff + 1'b1;

   // A zero length acts as one; a length beyond the ring saturates to its depth.
   always_comb begin
      if (cfg_len_ff == '0) begin
         eff_len = LW'(1);
      end else if (32'(cfg_len_ff) > WINDOW_DEPTH) begin
         eff_len = LW'(WINDOW_DEPTH);
      end else begin
         eff_len = cfg_len_ff;
      end
   end

   assign issue = (state_ff == S_SCAN) && (iss_k_ff != len_ff);

   // Accumulate one returned row, a divider step and the signed quotient per axis.
   always_comb begin
      for (int a = 0; a < NAX; a++) begin
         rd_val[a] = pend_zero_ff ? '0 : rd_data_ff[SW*a +: SW];
         sum_in[a] = sum_ff[a] + SUMW'(rd_val[a]);
         lo_in[a]  = (rd_val[a] < lo_ff[a]) ? rd_val[a] : lo_ff[a];
         hi_in[a]  = (rd_val[a] > hi_ff[a]) ? rd_val[a] : hi_ff[a];
         mag_in[a] = sum_ff[a][SUMW-1] ? SUMW'(-sum_ff[a]) : SUMW'(sum_ff[a]);
         trial[a]  = {rem_ff[a], quo_ff[a][SUMW-1]};
         qbit[a]   = (trial[a] >= {1'b0, len_ff});
         rem_in[a] = qbit[a] ? LW'(trial[a] - {1'b0, len_ff}) : trial[a][LW-1:0];
         mean[a]   = neg_ff[a] ? SW'(-quo_ff[a][SW-1:0]) : quo_ff[a][SW-1:0];
      end
   end

   // Ring memory: written on acceptance, read every cycle at the scan pointer.
   // A read never hits the slot written in the same item, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ring_ff[new_slot] <= {samp[2], samp[1], samp[0]};
      end
      rd_data_ff <= sample_ring_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cfg_len_ff   <= LW'(1);
         newest_ff    <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cfg_len_ff <= csr_data;
         end
         // The done state reloads the output register itself.
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  newest_ff <= new_slot;
                  if (fill_ff != FILL_W'(WINDOW_DEPTH)) begin
                     fill_ff <= fill_ff + 1'b1;
                  end
                  // The newest entry is taken straight from the request.
                  for (int a = 0; a < NAX; a++) begin
                     sum_ff[a] <= SUMW'(samp[a]);
                     lo_ff[a]  <= samp[a];
                     hi_ff[a]  <= samp[a];
                  end
                  rd_ptr_ff <= (new_slot == '0) ? ADDR_W'(WINDOW_DEPTH - 1)
                                                : new_slot - 1'b1;
                  len_ff    <= eff_len;
                  iss_k_ff  <= LW'(1);
                  pend_ff   <= 1'b0;
                  state_ff  <= S_SCAN;
               end
            end
            S_SCAN: begin
               pend_ff <= issue;
               if (issue) begin
                  rd_ptr_ff    <= (rd_ptr_ff == '0) ? ADDR_W'(WINDOW_DEPTH - 1)
                                                    : rd_ptr_ff - 1'b1;
                  iss_k_ff     <= iss_k_ff + 1'b1;
                  // Entries older than the number written since reset read as zero.
                  pend_zero_ff <= !(CMP_W'(iss_k_ff) < CMP_W'(fill_ff));
               end
               if (pend_ff) begin
                  for (int a = 0; a < NAX; a++) begin
                     sum_ff[a] <= sum_in[a];
                     lo_ff[a]  <= lo_in[a];
                     hi_ff[a]  <= hi_in[a];
                  end
               end
               if (!issue && !pend_ff) begin
                  for (int a = 0; a < NAX; a++) begin
                     quo_ff[a] <= mag_in[a];
                     rem_ff[a] <= '0;
                     neg_ff[a] <= sum_ff[a][SUMW-1];
                  end
                  div_cnt_ff <= DCW'(SUMW);
                  state_ff   <= S_DIV;
               end
            end
            S_DIV: begin
               for (int a = 0; a < NAX; a++) begin
                  rem_ff[a] <= rem_in[a];
                  quo_ff[a] <= {quo_ff[a][SUMW-2:0], qbit[a]};
               end
               div_cnt_ff <= div_cnt_ff - 1'b1;
               if (div_cnt_ff == DCW'(1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_data_ff.mean_x <= mean[0];
                  rsp_data_ff.mean_y <= mean[1];
                  rsp_data_ff.mean_z <= mean[2];
                  rsp_data_ff.low_x  <= lo_ff[0];
                  rsp_data_ff.high_x <= hi_ff[0];
                  rsp_data_ff.low_y  <= lo_ff[1];
                  rsp_data_ff.high_y <= hi_ff[1];
                  rsp_data_ff.low_z  <= lo_ff[2];
                  rsp_data_ff.high_z <= hi_ff[2];
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // An accepted transaction closes the request side for the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous item still in progress");

   // The fill count never passes the ring depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= WINDOW_DEPTH)
      else $error("fill count beyond ring depth");

   // A scan read never addresses the slot just written.
   a_read_not_newest: assert property (@(posedge clock) disable iff (reset)
      issue |-> rd_ptr_ff != newest_ff)
      else $error("scan read hits the newest slot");

   // The scan never issues more reads than the window holds.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> iss_k_ff <= len_ff)
      else $error("scan index beyond window length");

   // A result is only loaded when the output register is free or being drained.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("pending result overwritten");
`endif

endmodule

FILE: test/sliding_window_avg_min_max_core_tb.sv
// Self-checking testbench for the sliding-window average, minimum and maximum core.
`timescale 1ns / 1ps

// The bench drives three-axis samples into the core over the req_ channel and
// checks every result on the rsp_ channel against its own model of the window.
// The model keeps a copy of the ring store and of the window length. At each
// accepted request transaction it works out the mean, minimum and maximum per
// axis and queues them. The receiving side pops the oldest entry for every
// response transaction and compares all nine fields.
//
// A short directed plan comes first: field extremes, truncation of negative
// means toward zero, a zero window length, a length above the ring depth and
// windows that still reach into never-written, zero-filled entries. A series
// of random phases follows, each of which first programs a window length.
//
// Both sides insert random idle cycles. Some phases run with no idling at all.
// In two phases the receiver holds off for a long stretch so that the core
// backs up and stalls its input. In other phases the sender stops part-way
// until every outstanding result has come back.
module sliding_window_avg_min_max_core_tb;

   localparam int SAMPLE_W    = swamm_pkg::SAMPLE_W;
   localparam int AXES        = swamm_pkg::AXES;
   localparam int CFG_W       = swamm_pkg::CFG_W;
   localparam int WIN_DEPTH   = 1024;
   localparam int LONG_HOLD   = 400;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int NUM_FIELDS  = 9;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   swamm_pkg::req_type   req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   swamm_pkg::rsp_type   rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CFG_W-1:0]     csr_data;

   // One row of the directed plan. Where known is set, the expected result is
   // typed in. Otherwise it comes from the window model.
   typedef struct {
      int                 length;
      swamm_pkg::req_type sample;
      bit                 known;
      swamm_pkg::rsp_type want;
   } plan_row_type;

   plan_row_type plan [$];

   // The model's copy of the core state and of the programmed window length.
   logic signed [SAMPLE_W-1:0] ring_store [WIN_DEPTH][AXES];
   int                         newest_idx;
   logic [CFG_W-1:0]           win_len;

   swamm_pkg::rsp_type expected_q [$];
   bit                 idle_on;
   bit                 hold_pending;
   int                 errors;
   int                 samples_sent;
   int                 results_seen;
   int unsigned        cycle_count = 0;

   string field_name [NUM_FIELDS] = '{"mean_x", "mean_y", "mean_z", "low_x", "high_x",
                                      "low_y", "high_y", "low_z", "high_z"};

   sliding_window_avg_min_max_core #(
      .WINDOW_DEPTH (WIN_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // The clock has a 12 ns period and starts low, so the first rising edge comes at 6 ns.
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The watchdog catches a core that stops answering or never frees its input.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d results still outstanding",
                  cycle_count, expected_q.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endtask

   function automatic swamm_pkg::rsp_type result_of(input int mx, input int my,
                                                    input int mz, input int lx,
                                                    input int hx, input int ly,
                                                    input int hy, input int lz,
                                                    input int hz);
      swamm_pkg::rsp_type r;
      r.mean_x = SAMPLE_W'(mx);
      r.mean_y = SAMPLE_W'(my);
      r.mean_z = SAMPLE_W'(mz);
      r.low_x  = SAMPLE_W'(lx);
      r.high_x = SAMPLE_W'(hx);
      r.low_y  = SAMPLE_W'(ly);
      r.high_y = SAMPLE_W'(hy);
      r.low_z  = SAMPLE_W'(lz);
      r.high_z = SAMPLE_W'(hz);
      return r;
   endfunction

   // This function writes the new sample into the modelled ring and then scans
   // the most recent span entries, newest first. Entries that were never written
   // still hold the zeros from reset, so they take part like any other entry.
   // A zero length acts as one. A length above the ring depth is clamped to the depth.
   function automatic swamm_pkg::rsp_type slide_window(input swamm_pkg::req_type s);
      int                 span;
      int                 slot;
      int                 v;
      longint             sum [AXES];
      int                 lo [AXES];
      int                 hi [AXES];
      swamm_pkg::rsp_type r;
      span = int'(win_len);
      if (span < 1) span = 1;
      if (span > WIN_DEPTH) span = WIN_DEPTH;
      newest_idx = (newest_idx + 1) % WIN_DEPTH;
      ring_store[newest_idx][0] = s.sample_x;
      ring_store[newest_idx][1] = s.sample_y;
      ring_store[newest_idx][2] = s.sample_z;
      for (int a = 0; a < AXES; a++) begin
         sum[a] = 0;
         lo[a]  = ring_store[newest_idx][a];
         hi[a]  = lo[a];
      end
      for (int k = 0; k < span; k++) begin
         slot = (newest_idx + WIN_DEPTH - k) % WIN_DEPTH;
         for (int a = 0; a < AXES; a++) begin
            v = ring_store[slot][a];
            sum[a] += v;
            if (v < lo[a]) lo[a] = v;
            if (v > hi[a]) hi[a] = v;
         end
      end
      // Division of signed integers in SystemVerilog truncates toward zero, as the core does.
      r.mean_x = SAMPLE_W'(sum[0] / span);
      r.mean_y = SAMPLE_W'(sum[1] / span);
      r.mean_z = SAMPLE_W'(sum[2] / span);
      r.low_x  = SAMPLE_W'(lo[0]);
      r.high_x = SAMPLE_W'(hi[0]);
      r.low_y  = SAMPLE_W'(lo[1]);
      r.high_y = SAMPLE_W'(hi[1]);
      r.low_z  = SAMPLE_W'(lo[2]);
      r.high_z = SAMPLE_W'(hi[2]);
      return r;
   endfunction

   // Random axis values are weighted toward the two extremes, zero, minus one
   // and small magnitudes. A full-width value is still the most common choice,
   // so every bit takes both values.
   function automatic logic [SAMPLE_W-1:0] random_axis();
      int small_v;
      small_v = int'($urandom_range(0, 64)) - 32;
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4, 5: return SAMPLE_W'(small_v);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic add_row(input int length, input int x, input int y, input int z,
                          input bit known, input swamm_pkg::rsp_type want);
      plan_row_type row;
      row.length          = length;
      row.sample.sample_x = SAMPLE_W'(x);
      row.sample.sample_y = SAMPLE_W'(y);
      row.sample.sample_z = SAMPLE_W'(z);
      row.known           = known;
      row.want            = want;
      plan.push_back(row);
   endtask

   // This task offers one sample and holds it until the core accepts it. The
   // task returns at the rising edge where the transaction took place, with
   // valid still high. The next call either keeps valid up with fresh data or
   // drops it for a gap. Either way valid gets a single assignment in that step.
   task automatic send_sample(input swamm_pkg::req_type s, input bit known,
                              input swamm_pkg::rsp_type want);
      int                 gap;
      swamm_pkg::rsp_type predicted;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (!(req_valid && req_ready));
      predicted = slide_window(s);
      expected_q.push_back(known ? want : predicted);
      samples_sent++;
   endtask

   // This task stops offering samples and waits until every queued result has
   // been received. The wait is on a level, so it ends the same way whichever
   // process runs first at the receiving edge.
   task automatic drain_results();
      req_valid <= 1'b0;
      wait (expected_q.size() == 0);
      @(posedge clock);
   endtask

   // The window length is only changed while the core is idle. Every request
   // produces a result, so the core is idle once all results have come back.
   task automatic program_window(input int length);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= CFG_W'(length);
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      win_len = CFG_W'(length);
   endtask

   task automatic run_phase(input int length, input int count, input bit idle,
                            input bit hold, input bit pause_mid);
      program_window(length);
      idle_on      = idle;
      hold_pending = hold;
      for (int n = 0; n < count; n++) begin
         if (pause_mid && n == count / 2) drain_results();
         send_sample({random_axis(), random_axis(), random_axis()}, 1'b0, '0);
      end
   endtask

   // Receiving side. Before taking each result it waits a random number of
   // cycles. On request it instead holds off for a long stretch, which it counts
   // itself. It then checks the transaction against the oldest queued expectation.
   initial begin
      int                                    gap;
      swamm_pkg::rsp_type                    want;
      logic [$bits(swamm_pkg::rsp_type)-1:0] got_bits;
      logic [$bits(swamm_pkg::rsp_type)-1:0] want_bits;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            for (int c = 0; c < LONG_HOLD; c++) @(posedge clock);
         end else begin
            gap = idle_on ? $urandom_range(0, 8) : 0;
            if (gap != 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         got_bits = rsp_data;
         if (expected_q.size() == 0) begin
            flag_error($sformatf("result %0d arrived with nothing outstanding: %h",
                                 results_seen, got_bits));
         end else begin
            want      = expected_q.pop_front();
            want_bits = want;
            for (int f = 0; f < NUM_FIELDS; f++) begin
               if (got_bits[(NUM_FIELDS-1-f)*SAMPLE_W +: SAMPLE_W] !==
                   want_bits[(NUM_FIELDS-1-f)*SAMPLE_W +: SAMPLE_W]) begin
                  flag_error($sformatf("result %0d field %s: got %h, expected %h",
                             results_seen, field_name[f],
                             got_bits[(NUM_FIELDS-1-f)*SAMPLE_W +: SAMPLE_W],
                             want_bits[(NUM_FIELDS-1-f)*SAMPLE_W +: SAMPLE_W]));
               end
            end
         end
         results_seen++;
      end
   end

   // Main sequence: reset, the directed plan, the random phases and then the drain.
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      idle_on      = 1'b1;
      hold_pending = 1'b0;
      errors       = 0;
      samples_sent = 0;
      results_seen = 0;
      newest_idx   = 0;
      win_len      = CFG_W'(1);
      for (int i = 0; i < WIN_DEPTH; i++) begin
         for (int a = 0; a < AXES; a++) ring_store[i][a] = '0;
      end

      // With a window of one, each result is simply the sample itself.
      add_row(1, 32767, -32768, 0, 1'b1,
              result_of(32767, -32768, 0, 32767, 32767, -32768, -32768, 0, 0));
      add_row(1, -32768, 32767, -1, 1'b1,
              result_of(-32768, 32767, -1, -32768, -32768, 32767, 32767, -1, -1));
      add_row(1, 1, -1, 1024, 1'b1,
              result_of(1, -1, 1024, 1, 1, -1, -1, 1024, 1024));
      // A zero length behaves like a window of one.
      add_row(0, 4660, -4660, 5, 1'b1,
              result_of(4660, -4660, 5, 4660, 4660, -4660, -4660, 5, 5));
      // Negative means must truncate toward zero: -3/2 gives -1, and -1/2 gives 0.
      add_row(2, -3, 3, -1, 1'b0, '0);
      add_row(2, 0, 0, 0, 1'b1, result_of(-1, 1, 0, -3, 0, 0, 3, -1, 0));
      // Two equal extremes must give the extreme as their mean, with no overflow.
      add_row(2, -32768, -32768, -32768, 1'b0, '0);
      add_row(2, -32768, -32768, -32768, 1'b1,
              result_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                        -32768, -32768));
      add_row(2, 32767, 32767, 32767, 1'b0, '0);
      add_row(2, 32767, 32767, 32767, 1'b1,
              result_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      // This window is longer than the history so far, so reset zeros fall inside it.
      add_row(16, 21845, -21846, 255, 1'b0, '0);
      add_row(16, -21846, 21845, -256, 1'b0, '0);
      // A length above the ring depth is clamped to the full ring.
      add_row(2047, -32768, 32767, -32768, 1'b0, '0);
      add_row(1024, 32767, -32768, 32767, 1'b0, '0);
      add_row(1024, 0, 0, 0, 1'b0, '0);
      // The next two lengths shrink the window again over the same history.
      add_row(5, 100, -100, 7, 1'b0, '0);
      add_row(5, -7, 7, -100, 1'b0, '0);
      add_row(3, 16384, -16384, 1, 1'b0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].length != int'(win_len)) program_window(plan[i].length);
         send_sample(plan[i].sample, plan[i].known, plan[i].want);
      end

      // Random phases. Most use short windows and only a few the full ring. Some
      // run with no idling. In two phases the receiver stalls long enough for the
      // input to back up, and in others the sender pauses part-way until all
      // outstanding results have arrived.
      run_phase(3, 80, 1'b1, 1'b0, 1'b0);
      run_phase(1, 60, 1'b0, 1'b0, 1'b0);
      run_phase(0, 20, 1'b1, 1'b0, 1'b0);
      run_phase(7, 80, 1'b0, 1'b1, 1'b0);
      run_phase(1024, 25, 1'b1, 1'b0, 1'b0);
      run_phase(2047, 15, 1'b1, 1'b0, 1'b0);
      run_phase(64, 60, 1'b1, 1'b0, 1'b1);
      run_phase(2, 80, 1'b0, 1'b0, 1'b1);
      run_phase(1, 40, 1'b1, 1'b1, 1'b0);
      run_phase(200, 40, 1'b1, 1'b0, 1'b0);
      repeat (3) run_phase($urandom_range(1, 40), 25, 1'b1, 1'b0, 1'b0);

      drain_results();
      // Allow time for a full-ring window: any stray extra result would show up here.
      repeat (WIN_DEPTH + 64) @(posedge clock);

      $display("Summary: %0d samples sent and %0d results checked, window lengths 0 to 2047",
               samples_sent, results_seen);
      $display("Summary: covered part-filled and clamped windows and a %0d-cycle output stall",
               LONG_HOLD);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
